// ===== hdl/stream_byte_reassembler_unit_assert.svh =====
// Assertion macros for the stream byte reassembler.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef STREAM_BYTE_REASSEMBLER_UNIT_ASSERT_SVH
`define STREAM_BYTE_REASSEMBLER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sbr_pkg.sv =====
// Shared widths and beat types of the stream byte reassembler.
// No dependencies.
package sbr_pkg;

    localparam int unsigned IDX_W   = 32;
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned SPACE_W = 7;
    localparam int unsigned CNT_W   = 7;

    // One segment byte beat
    typedef struct packed {
        logic [IDX_W-1:0]   seg_start;
        logic [IDX_W-1:0]   byte_pos;
        logic [DATA_W-1:0]  data_byte;
        logic               has_byte;
        logic               seg_last;
        logic               eof_flag;
        logic [SPACE_W-1:0] out_space;
    } t_seg_beat;

    // One assembled result beat
    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              byte_valid;
        logic              run_last;
        logic              end_of_stream;
        logic [CNT_W-1:0]  pending_count;
    } t_asm_beat;

endpackage

// ===== hdl/sbr_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
// The payload type is chosen per instance (see sbr_pkg).
interface sbr_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/stream_byte_reassembler_unit.sv =====
// Stream byte reassembler. Segment bytes arrive one per beat with their stream
// position; bytes inside the current window are kept once in a ring of CAPACITY
// bytes, and on a segment's last beat the in-order run from the next expected
// position is sent out, one result beat per byte (or one status beat if none).
// An old segment skips the scan. A segment end within the window scans the valid
// bits one slot per cycle to size the run, then the single ring read port returns
// one byte per cycle while the output accepts them. Valid bits live in flops, so
// the block is ready right after reset with no clearing pass.
`include "stream_byte_reassembler_unit_assert.svh"

module stream_byte_reassembler_unit import sbr_pkg::*; #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sbr_stream_if.sink   i_seg,
    sbr_stream_if.source o_asm
);

    localparam int unsigned SW = $clog2(CAPACITY);
    localparam int unsigned PW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
    localparam logic [SW:0]   CAP_S = (SW+1)'(CAPACITY);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_CHECK  = 6'b001000,
        S_STATUS = 6'b010000,
        S_DRAIN  = 6'b100000
    } t_state;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        logic [SW-1:0] v;
        v = (s == SW'(CAPACITY - 1)) ? '0 : s + SW'(1);
        return v;
    endfunction

    // control state
    t_state              r_state,     n_state;
    logic [IDX_W-1:0]    r_next,      n_next;
    logic [SW-1:0]       r_head,      n_head;
    logic [CAPACITY-1:0] r_valid,     n_valid;
    logic [PW-1:0]       r_pending,   n_pending;
    logic [IDX_W-1:0]    r_eof_pos,   n_eof_pos;
    logic                r_eof_known, n_eof_known;
    logic                r_ended,     n_ended;
    logic                r_out_valid, n_out_valid;
    logic                r_rd_pend,   n_rd_pend;
    logic [PW-1:0]       r_rd_left,   n_rd_left;
    logic [PW-1:0]       r_emit_left, n_emit_left;

    // beat and working registers
    logic [IDX_W-1:0]    r_seg_start, n_seg_start;
    logic [IDX_W-1:0]    r_seg_end,   n_seg_end;
    logic [PW-1:0]       r_space,     n_space;
    logic                r_last,      n_last;
    logic                r_eof_req,   n_eof_req;
    logic [PW-1:0]       r_cnt,       n_cnt;
    logic [SW-1:0]       r_scan_slot, n_scan_slot;
    logic [SW-1:0]       r_rd_slot,   n_rd_slot;
    t_asm_beat           r_out,       n_out;

    t_seg_beat           w_in;
    logic                w_accept;
    logic                w_out_free;
    logic [PW-1:0]       w_space_in;
    logic [IDX_W:0]      w_diff;
    logic                w_in_win;
    logic [SW:0]         w_slot_sum;
    logic [SW-1:0]       w_wr_slot;
    logic                w_store;
    logic [IDX_W-1:0]    w_seg_end;
    logic                w_old;
    logic [IDX_W:0]      w_win_end;
    logic                w_beyond;
    logic                w_scan_hit;
    logic [IDX_W-1:0]    w_next_new;
    logic                w_end_hit;
    logic [SW:0]         w_head_sum;
    logic [SW-1:0]       w_head_new;
    logic                w_status;
    logic                w_move;
    logic                w_rd_en;
    logic [DATA_W-1:0]   w_rd_data;

    assign w_in        = i_seg.payload;
    assign i_seg.ready = (r_state == S_IDLE);
    assign w_accept    = i_seg.valid && i_seg.ready;

    assign o_asm.valid   = r_out_valid;
    assign o_asm.payload = r_out;
    assign w_out_free    = !r_out_valid || o_asm.ready;

    // window check and ring slot of the incoming byte
    assign w_space_in = (w_in.out_space > SPACE_W'(CAPACITY)) ? CAP_P
                                                               : w_in.out_space[PW-1:0];
    assign w_diff     = {1'b0, w_in.byte_pos} - {1'b0, r_next};
    assign w_in_win   = w_in.has_byte && !w_diff[IDX_W]
                        && (w_diff[IDX_W-1:0] < IDX_W'(w_space_in));
    assign w_slot_sum = {1'b0, r_head} + {1'b0, w_diff[SW-1:0]};
    assign w_wr_slot  = (w_slot_sum >= CAP_S) ? SW'(w_slot_sum - CAP_S) : w_slot_sum[SW-1:0];
    assign w_store    = w_accept && w_in_win && !r_valid[w_wr_slot];

    // segment end, saturated at all ones
    assign w_seg_end = !w_in.has_byte ? w_in.seg_start
                     : (&w_in.byte_pos) ? w_in.byte_pos
                     : w_in.byte_pos + IDX_W'(1);

    // segment classification
    assign w_old     = (r_seg_end <= r_next);
    assign w_win_end = {1'b0, r_next} + (IDX_W+1)'(r_space);
    assign w_beyond  = ({1'b0, r_seg_start} >= w_win_end);

    // run scan over valid bits
    assign w_scan_hit = (r_cnt != r_space) && r_valid[r_scan_slot];

    // commit of the run length and end-of-stream check
    assign w_next_new = r_next + IDX_W'(r_cnt);
    assign w_end_hit  = r_eof_known && (r_eof_pos <= w_next_new) && (r_pending == r_cnt);
    assign w_head_sum = {1'b0, r_head} + (SW+1)'(r_cnt);
    assign w_head_new = (w_head_sum >= CAP_S) ? SW'(w_head_sum - CAP_S)
                                              : w_head_sum[SW-1:0];

    sbr_byte_ring #(
        .DEPTH (CAPACITY)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_store),
        .i_wr_addr (w_wr_slot),
        .i_wr_data (w_in.data_byte),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_slot),
        .o_rd_data (w_rd_data)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_next      = r_next;
        n_head      = r_head;
        n_valid     = r_valid;
        n_pending   = r_pending;
        n_eof_pos   = r_eof_pos;
        n_eof_known = r_eof_known;
        n_ended     = r_ended;
        n_out_valid = r_out_valid && !o_asm.ready;
        n_rd_pend   = r_rd_pend;
        n_rd_left   = r_rd_left;
        n_emit_left = r_emit_left;
        n_seg_start = r_seg_start;
        n_seg_end   = r_seg_end;
        n_space     = r_space;
        n_last      = r_last;
        n_eof_req   = r_eof_req;
        n_cnt       = r_cnt;
        n_scan_slot = r_scan_slot;
        n_rd_slot   = r_rd_slot;
        n_out       = r_out;
        w_status    = 1'b0;
        w_move      = 1'b0;
        w_rd_en     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_seg_start = w_in.seg_start;
                    n_seg_end   = w_seg_end;
                    n_space     = w_space_in;
                    n_last      = w_in.seg_last;
                    n_eof_req   = w_in.eof_flag;
                    if (w_store) begin
                        n_valid[w_wr_slot] = 1'b1;
                        n_pending          = r_pending + PW'(1);
                    end
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_last && r_eof_req) begin
                    if (r_seg_end < r_eof_pos) begin
                        n_eof_pos = r_seg_end;
                    end
                    n_eof_known = 1'b1;
                end
                n_scan_slot = r_head;
                n_cnt       = '0;
                if (!r_last || (!w_old && w_beyond)) begin
                    if (w_out_free) begin
                        w_status = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_STATUS;
                    end
                end else if (w_old) begin
                    n_state = S_CHECK;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_hit) begin
                    n_cnt       = r_cnt + PW'(1);
                    n_scan_slot = slot_inc(r_scan_slot);
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_next      = w_next_new;
                n_pending   = r_pending - r_cnt;
                n_head      = w_head_new;
                n_rd_slot   = r_head;
                n_rd_left   = r_cnt;
                n_emit_left = r_cnt;
                n_rd_pend   = 1'b0;
                if (w_end_hit) begin
                    n_ended = 1'b1;
                end
                n_state = (r_cnt == '0) ? S_STATUS : S_DRAIN;
            end
            S_STATUS: begin
                if (w_out_free) begin
                    w_status = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_DRAIN: begin
                // hand the read byte to the output register
                w_move = r_rd_pend && w_out_free;
                // issue the next ring read when its data has a place to land
                w_rd_en = (r_rd_left != '0) && (!r_rd_pend || w_move);
                if (w_move) begin
                    n_out.out_byte      = w_rd_data;
                    n_out.byte_valid    = 1'b1;
                    n_out.run_last      = (r_emit_left == PW'(1));
                    n_out.end_of_stream = r_ended;
                    n_out.pending_count = CNT_W'(r_pending);
                    n_out_valid         = 1'b1;
                    n_emit_left         = r_emit_left - PW'(1);
                    if (r_emit_left == PW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
                if (w_rd_en) begin
                    n_valid[r_rd_slot] = 1'b0;
                    n_rd_slot          = slot_inc(r_rd_slot);
                    n_rd_left          = r_rd_left - PW'(1);
                end
                n_rd_pend = w_rd_en ? 1'b1 : (w_move ? 1'b0 : r_rd_pend);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // status beat: no byte, current counters
        if (w_status) begin
            n_out.out_byte      = '0;
            n_out.byte_valid    = 1'b0;
            n_out.run_last      = 1'b1;
            n_out.end_of_stream = r_ended;
            n_out.pending_count = CNT_W'(r_pending);
            n_out_valid         = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next      <= '0;
            r_head      <= '0;
            r_valid     <= '0;
            r_pending   <= '0;
            r_eof_pos   <= '1;
            r_eof_known <= 1'b0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_rd_left   <= '0;
            r_emit_left <= '0;
        end else begin
            r_state     <= n_state;
            r_next      <= n_next;
            r_head      <= n_head;
            r_valid     <= n_valid;
            r_pending   <= n_pending;
            r_eof_pos   <= n_eof_pos;
            r_eof_known <= n_eof_known;
            r_ended     <= n_ended;
            r_out_valid <= n_out_valid;
            r_rd_pend   <= n_rd_pend;
            r_rd_left   <= n_rd_left;
            r_emit_left <= n_emit_left;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_seg_start <= n_seg_start;
        r_seg_end   <= n_seg_end;
        r_space     <= n_space;
        r_last      <= n_last;
        r_eof_req   <= n_eof_req;
        r_cnt       <= n_cnt;
        r_scan_slot <= n_scan_slot;
        r_rd_slot   <= n_rd_slot;
        r_out       <= n_out;
    end

    // checks
    `SBR_ASSERT_SAME(a_pending_bound, 1'b1, r_pending <= CAP_P, "pending bytes above capacity")
    `SBR_ASSERT_SAME(a_valid_count, r_state == S_IDLE, $countones(r_valid) == int'(r_pending), "valid bits disagree with pending count")
    `SBR_ASSERT_SAME(a_drain_balance, r_state == S_DRAIN, r_emit_left == (r_rd_left + PW'(r_rd_pend)), "drain read and emit counts out of step")
    `SBR_ASSERT_NEXT(a_ended_sticky, r_ended, r_ended, "end of stream dropped")

endmodule

// ===== hdl/sbr_byte_ring.sv =====
// Byte ring storage: one write port, one read port with registered data.
// Depends on sbr_pkg for the data width.
module sbr_byte_ring import sbr_pkg::*; #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for stream_byte_reassembler_unit.
// Depends on hdl/sbr_pkg.sv, hdl/sbr_stream_if.sv and the unit itself; it drives segment
// beats and checks every assembled beat against the directed table or an in-bench predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sbr_pkg::*;

    localparam int unsigned RING         = 64;
    localparam int unsigned RANDOM_BEATS = 290;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned SETTLE       = 300;
    localparam int unsigned IDLE_PCT     = 38;
    localparam int unsigned MAX_REPORTS  = 10;

    // One row of the directed table; want is used only when typed is set
    typedef struct {
        t_seg_beat beat;
        bit        typed;
        t_asm_beat want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    sbr_stream_if #(.t_payload(t_seg_beat)) seg_if ();
    sbr_stream_if #(.t_payload(t_asm_beat)) asm_if ();

    stream_byte_reassembler_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_if),
        .o_asm   (asm_if)
    );

    // Predictor state
    logic [7:0]  ring_bytes [RING];
    bit          ring_full  [RING];
    logic [31:0] next_pos;
    logic [31:0] eof_pos;
    bit          eof_seen;
    logic [6:0]  held_bytes;
    bit          stream_done;

    t_asm_beat   run_beats [$];   // beats of the beat just predicted
    t_asm_beat   due_beats [$];   // assembled beats still awaited from the unit
    t_dir_row    dir_rows  [$];   // directed stimulus table

    int unsigned beats_sent;
    int unsigned mismatches;
    int unsigned cycles;
    bit          calm;            // no idling on either side while set

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        asm_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && asm_if.valid && asm_if.ready) begin
            check_beat(asm_if.payload);
        end
    end

    function automatic void check_done();
        if (eof_seen && eof_pos <= next_pos && held_bytes == 7'd0) begin
            stream_done = 1'b1;
        end
    endfunction

    function automatic t_asm_beat idle_beat(bit eos, logic [6:0] held);
        return '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1,
                 end_of_stream: eos, pending_count: held};
    endfunction

    // Store the beat's byte, and on a segment end drain the in-order run
    function automatic void reassemble(input t_seg_beat b);
        logic [32:0] win_end;
        logic [31:0] seg_end;
        int unsigned room;
        int unsigned left;
        int unsigned slot;
        t_asm_beat   beat;
        room    = (b.out_space > RING) ? RING : b.out_space;
        win_end = {1'b0, next_pos} + 33'(room);
        run_beats.delete();

        if (b.has_byte && b.byte_pos >= next_pos && {1'b0, b.byte_pos} < win_end) begin
            slot = b.byte_pos % RING;
            if (!ring_full[slot]) begin
                ring_full[slot]  = 1'b1;
                ring_bytes[slot] = b.data_byte;
                held_bytes       = held_bytes + 7'd1;
            end
        end

        if (b.seg_last) begin
            if (!b.has_byte) begin
                seg_end = b.seg_start;
            end else if (&b.byte_pos) begin
                seg_end = '1;
            end else begin
                seg_end = b.byte_pos + 32'd1;
            end
            if (b.eof_flag) begin
                if (seg_end < eof_pos) eof_pos = seg_end;
                eof_seen = 1'b1;
            end
            if (seg_end <= next_pos) begin
                check_done();
            end else if ({1'b0, b.seg_start} < win_end) begin
                left = room;
                slot = next_pos % RING;
                while (left > 0 && ring_full[slot]) begin
                    beat = '{out_byte: ring_bytes[slot], byte_valid: 1'b1, run_last: 1'b0,
                             end_of_stream: 1'b0, pending_count: 7'd0};
                    run_beats = {run_beats, beat};
                    ring_full[slot] = 1'b0;
                    next_pos        = next_pos + 32'd1;
                    held_bytes      = held_bytes - 7'd1;
                    left            = left - 1;
                    slot            = next_pos % RING;
                end
                check_done();
            end
            // beyond the window nothing happens, not even the end check
        end

        if (run_beats.size() == 0) run_beats = {run_beats, idle_beat(1'b0, 7'd0)};
        foreach (run_beats[k]) begin
            beat               = run_beats[k];
            beat.end_of_stream = stream_done;
            beat.pending_count = held_bytes;
            beat.run_last      = (k == run_beats.size() - 1);
            run_beats[k]       = beat;
        end
    endfunction

    function automatic void check_beat(input t_asm_beat got);
        t_asm_beat want;
        if (due_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("unexpected beat: byte %02h valid %0d last %0d eos %0d pend %0d",
                         got.out_byte, got.byte_valid, got.run_last, got.end_of_stream,
                         got.pending_count);
            end
            return;
        end
        want = due_beats.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
            got.run_last !== want.run_last || got.end_of_stream !== want.end_of_stream ||
            got.pending_count !== want.pending_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("mismatch: exp byte %02h valid %0d last %0d eos %0d pend %0d",
                         want.out_byte, want.byte_valid, want.run_last,
                         want.end_of_stream, want.pending_count);
                $display("          got byte %02h valid %0d last %0d eos %0d pend %0d",
                         got.out_byte, got.byte_valid, got.run_last,
                         got.end_of_stream, got.pending_count);
            end
        end
    endfunction

    function automatic t_seg_beat seg_beat(logic [31:0] start, logic [31:0] pos,
                                           logic [7:0] data, bit has, bit last, bit eof,
                                           logic [6:0] room);
        return '{seg_start: start, byte_pos: pos, data_byte: data, has_byte: has,
                 seg_last: last, eof_flag: eof, out_space: room};
    endfunction

    // Append one row to the directed table
    function automatic void add_row(t_seg_beat b, bit typed, t_asm_beat want);
        t_dir_row row;
        row      = '{beat: b, typed: typed, want: want};
        dir_rows = {dir_rows, row};
    endfunction

    // Present one segment beat, wait for the handshake, then queue its results
    task automatic send_beat(input t_seg_beat b, input bit typed, input t_asm_beat want);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            seg_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg_if.valid   <= 1'b1;
        seg_if.payload <= b;
        @(posedge i_clk);
        while (!seg_if.ready) @(posedge i_clk);
        reassemble(b);
        if (typed) begin
            due_beats = {due_beats, want};
        end else begin
            due_beats = {due_beats, run_beats};
        end
        beats_sent++;
        calm = (beats_sent >= 150 && beats_sent < 230);
    endtask

    // Segment of len bytes from start; bytes out of order, the final byte carries seg_last
    // unless cut. With vary set, out_space now and then changes within the segment.
    task automatic send_segment(input logic [31:0] start, input int len,
                                input logic [6:0] room, input bit eof,
                                input bit cut, input bit vary);
        int         order [RING];
        int         i;
        int         j;
        int         tmp;
        bit         last;
        logic [6:0] sp;
        for (i = 0; i < len; i++) order[i] = i;
        for (i = len - 2; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < len; i++) begin
            last = (i == len - 1) && !cut;
            sp   = (vary && $urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127)) : room;
            // eof_flag on a non-last beat must be ignored
            send_beat(seg_beat(start, start + 32'(order[i]), 8'($urandom_range(0, 255)),
                               1'b1, last, last ? eof : 1'($urandom_range(0, 1)), sp),
                      1'b0, '0);
        end
    endtask

    // Stimulus
    initial begin
        int unsigned pick;
        int          len;
        int          k;
        logic [31:0] start;
        logic [6:0]  room;
        t_seg_beat   b;

        i_rst_n        = 1'b0;
        seg_if.valid   = 1'b0;
        seg_if.payload = '0;
        beats_sent     = 0;
        mismatches     = 0;
        calm           = 1'b0;
        next_pos       = '0;
        eof_pos        = '1;
        eof_seen       = 1'b0;
        held_bytes     = '0;
        stream_done    = 1'b0;
        foreach (ring_full[s]) ring_full[s] = 1'b0;

        // empty segment right after reset is old
        add_row(seg_beat(32'd0, 32'd0, 8'h00, 1'b0, 1'b1, 1'b0, 7'd0), 1'b1,
                idle_beat(1'b0, 7'd0));
        // top index, oversized space: beyond the window
        add_row(seg_beat('1, '1, 8'hFF, 1'b1, 1'b0, 1'b0, 7'd127), 1'b1,
                idle_beat(1'b0, 7'd0));
        // eof at the top index: end saturates, segment beyond the window
        add_row(seg_beat('1, '1, 8'hFF, 1'b1, 1'b1, 1'b1, 7'd127), 1'b1,
                idle_beat(1'b0, 7'd0));
        // out-of-order stores, eof on a non-last beat ignored
        add_row(seg_beat(32'd0, 32'd1, 8'hAA, 1'b1, 1'b0, 1'b1, 7'd64), 1'b1,
                idle_beat(1'b0, 7'd1));
        add_row(seg_beat(32'd0, 32'd2, 8'h55, 1'b1, 1'b0, 1'b0, 7'd64), 1'b1,
                idle_beat(1'b0, 7'd2));
        // duplicate byte
        add_row(seg_beat(32'd0, 32'd1, 8'h11, 1'b1, 1'b0, 1'b0, 7'd64), 1'b1,
                idle_beat(1'b0, 7'd2));
        // just past the window edge, then the last slot inside it
        add_row(seg_beat(32'd0, 32'd64, 8'h77, 1'b1, 1'b0, 1'b0, 7'd64), 1'b1,
                idle_beat(1'b0, 7'd2));
        add_row(seg_beat(32'd0, 32'd63, 8'h3C, 1'b1, 1'b0, 1'b0, 7'd64), 1'b1,
                idle_beat(1'b0, 7'd3));
        // fills the hole at 0 and drains three bytes
        add_row(seg_beat(32'd0, 32'd0, 8'h00, 1'b1, 1'b1, 1'b0, 7'd127), 1'b0, '0);
        // zero space: nothing stored, segment beyond the window
        add_row(seg_beat(32'd3, 32'd3, 8'hC3, 1'b1, 1'b1, 1'b0, 7'd0), 1'b1,
                idle_beat(1'b0, 7'd1));
        // small space limits both storing and draining
        add_row(seg_beat(32'd3, 32'd3, 8'hC3, 1'b1, 1'b0, 1'b0, 7'd2), 1'b1,
                idle_beat(1'b0, 7'd2));
        add_row(seg_beat(32'd3, 32'd4, 8'h5A, 1'b1, 1'b0, 1'b0, 7'd2), 1'b1,
                idle_beat(1'b0, 7'd3));
        add_row(seg_beat(32'd3, 32'd5, 8'hA5, 1'b1, 1'b0, 1'b0, 7'd2), 1'b1,
                idle_beat(1'b0, 7'd3));
        add_row(seg_beat(32'd3, 32'd5, 8'hA5, 1'b1, 1'b1, 1'b0, 7'd1), 1'b0, '0);
        // retransmitted old segment
        add_row(seg_beat(32'd0, 32'd2, 8'hEE, 1'b1, 1'b1, 1'b0, 7'd64), 1'b1,
                idle_beat(1'b0, 7'd2));
        // empty segment ahead of next drains
        add_row(seg_beat(32'd5, 32'd0, 8'h00, 1'b0, 1'b1, 1'b0, 7'd64), 1'b0, '0);
        // space above capacity is clamped
        add_row(seg_beat(32'd5, 32'd5, 8'h0F, 1'b1, 1'b1, 1'b0, 7'd70), 1'b0, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) send_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].want);

        // Random part: mostly well-formed segments, some old, empty, broken and noise
        while (beats_sent < RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                start = next_pos;
                if ($urandom_range(0, 3) == 0) begin
                    start = next_pos + 32'($urandom_range(1, 30));
                end else if ($urandom_range(0, 4) == 0 && next_pos >= 4) begin
                    start = next_pos - 32'($urandom_range(1, 4));
                end
                len  = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 64)
                                                    : $urandom_range(1, 10);
                room = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) : 7'd64;
                send_segment(start, len, room, 1'b0, 1'b0, 1'b1);
            end else if (pick < 68) begin
                b = seg_beat(next_pos + 32'($urandom_range(0, 3)), $urandom(),
                             8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0,
                             7'($urandom_range(0, 127)));
                send_beat(b, 1'b0, '0);
            end else if (pick < 78) begin
                k = $urandom_range(1, 8);
                if (next_pos >= 32'(k)) begin
                    send_segment(next_pos - 32'(k), k, 7'd64, 1'b0, 1'b0, 1'b1);
                end
            end else if (pick < 90) begin
                if ($urandom_range(0, 1) == 0) begin
                    b = seg_beat($urandom(), $urandom(), 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
                end else begin
                    b = seg_beat(next_pos + 32'($urandom_range(0, 40)),
                                 next_pos + 32'($urandom_range(0, 70)),
                                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'b0,
                                 7'($urandom_range(0, 127)));
                end
                send_beat(b, 1'b0, '0);
            end else begin
                send_segment(next_pos + 32'($urandom_range(0, 10)), $urandom_range(2, 6),
                             7'd64, 1'b0, 1'b1, 1'b1);
            end
        end

        // Closing segment fills the whole ring, drains 64 bytes and ends the stream
        send_segment(next_pos, 64, 7'd64, 1'b1, 1'b0, 1'b0);
        // end of stream stays set
        send_beat(seg_beat(next_pos, 32'd0, 8'h00, 1'b0, 1'b1, 1'b0, 7'd0), 1'b0, '0);
        seg_if.valid <= 1'b0;

        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0 && due_beats.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
